// File: rtl/prew_pkg.sv
// Shared types and constants of the 3x3 Prewitt edge filter.
// No dependencies; every other file of the block but prew_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prew_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = COL_W + 1;          // holds the effective width itself
    localparam int WCFG_W     = 11;
    localparam int ROW_W      = 16;
    localparam int CNT_ROW_W  = ROW_W + 1;          // drain rows run up to height + 1
    localparam int CH_W       = 8;
    localparam int PIX_W      = 10;
    localparam int VAL_W      = 13;
    localparam int SUM_W      = VAL_W - 1;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_DIRECTION = 2'd2;

    localparam logic KIND_PIXEL     = 1'b0;
    localparam logic KIND_FLUSH     = 1'b1;
    localparam logic DIR_VERTICAL   = 1'b0;
    localparam logic DIR_HORIZONTAL = 1'b1;

    localparam logic [WCFG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT = 16'd1024;

    localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

    // Effective frame geometry, already clamped.
    typedef struct packed {
        logic [EW_W-1:0]  width;
        logic [ROW_W-1:0] height;
    } t_geom;

    // One classified item handed from front to back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             have;
        logic [ROW_W-1:0] er;
        logic [COL_W-1:0] ec;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
    } t_rec;

    // One result item.
    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] max_val;
        logic signed [VAL_W-1:0] min_val;
        logic                    last;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/prew_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first: a same-cycle write to the read address is not seen
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/prew_front.sv
// Front end: accepts items, tracks the input position and classifies each item
// (dropped flush, pixel, drain tick, emitted position). Depends on prew_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prew_front import prew_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_geom           i_geom,
    input  wire logic            i_restart,
    input  wire logic            i_push,
    input  wire logic            i_full,
    input  wire logic            i_kind,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    output logic                 o_wr_en,
    output t_rec                 o_rec
);

    logic [COL_W-1:0]     r_in_col, n_in_col;
    logic [CNT_ROW_W-1:0] r_in_row, n_in_row;

    logic                 accept;
    logic                 real_pix;
    logic                 drop;
    logic [COL_W-1:0]     col;
    logic                 col_nz;
    logic [CNT_ROW_W-1:0] row_m;
    logic [EW_W-1:0]      w_m1;
    logic [EW_W-1:0]      col_inc;
    t_rec                 rec;

    always_comb begin
        accept   = i_push && !i_full;
        real_pix = r_in_row < {1'b0, i_geom.height};
        drop     = (i_kind == KIND_FLUSH) && real_pix;
        col      = ({1'b0, r_in_col} >= i_geom.width) ? '0 : r_in_col;
        col_nz   = col != '0;
        w_m1     = i_geom.width - EW_W'(1);
        // a column > 0 emits its upper-left neighbor, column 0 closes the row two back
        row_m    = col_nz ? r_in_row - CNT_ROW_W'(1) : r_in_row - CNT_ROW_W'(2);

        rec.col      = col;
        rec.pix      = real_pix ? (PIX_W'(i_red) + PIX_W'(i_green) + PIX_W'(i_blue)) : '0;
        rec.have     = col_nz ? (r_in_row >= CNT_ROW_W'(1)) : (r_in_row >= CNT_ROW_W'(2));
        rec.er       = row_m[ROW_W-1:0];
        rec.ec       = col_nz ? col - COL_W'(1) : w_m1[COL_W-1:0];
        rec.top_ok   = rec.er != '0;
        rec.bot_ok   = rec.er != (i_geom.height - ROW_W'(1));
        rec.left_ok  = rec.ec != '0;
        rec.right_ok = {1'b0, rec.ec} != w_m1;
        rec.last     = rec.have && !rec.bot_ok && !rec.right_ok;

        col_inc  = {1'b0, col} + EW_W'(1);
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (i_restart) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (accept && !drop) begin
            if (rec.last) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (col_inc >= i_geom.width) begin
                n_in_col = '0;
                n_in_row = r_in_row + CNT_ROW_W'(1);
            end else begin
                n_in_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    assign o_wr_en = accept && !drop;
    assign o_rec   = rec;

endmodule

`default_nettype wire

// File: rtl/prew_queue.sv
// Short flop queue of classified items between front and back.
// Depends on prew_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prew_queue import prew_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_rec      o_data
);

    t_rec             r_mem [IQ_DEPTH];
    logic [IQ_AW-1:0] r_wr_ptr;
    logic [IQ_AW-1:0] r_rd_ptr;
    logic [IQ_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == (IQ_AW+1)'(IQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + IQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + IQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (IQ_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (IQ_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/prew_back.sv
// Back end: line-store RAM, 3x3 window, Prewitt kernel, running max/min and
// result queue. Depends on prew_pkg and prew_ram.
`timescale 1ns / 1ps
`default_nettype none

module prew_back import prew_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_dir,
    input  wire logic i_restart,
    input  wire logic i_q_empty,
    input  wire t_rec i_q_data,
    output logic      o_q_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);

    // stage A: line-store read in flight
    logic              r_a_valid;
    t_rec              r_a_rec;
    logic              r_a_fwd;
    logic [LINE_W-1:0] r_a_fwd_data;

    // stage C: kernel result
    logic                    r_c_valid;
    logic signed [VAL_W-1:0] r_c_val;
    logic [COL_W-1:0]        r_c_col;
    logic [ROW_W-1:0]        r_c_row;
    logic                    r_c_last;

    logic signed [VAL_W-1:0] r_max, n_max;
    logic signed [VAL_W-1:0] r_min, n_min;

    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];

    t_res             r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wr;
    logic [OQ_AW-1:0] r_oq_rd;
    logic [OQ_AW:0]   r_oq_count;

    logic [LINE_W-1:0]       rd_data;
    logic [LINE_W-1:0]       lines;
    logic [LINE_W-1:0]       wr_data;
    logic [PIX_W-1:0]        above2;
    logic [PIX_W-1:0]        above1;
    logic [PIX_W-1:0]        tap [3][3];
    logic [2:0]              row_ok;
    logic [2:0]              col_ok;
    logic [SUM_W-1:0]        pos_sum;
    logic [SUM_W-1:0]        neg_sum;
    logic signed [VAL_W-1:0] val;
    logic [OQ_AW+1:0]        inflight;
    logic                    oq_pop;
    t_res                    res;

    // an item enters only if its result is sure of a place in the result queue
    assign inflight = (OQ_AW+2)'(r_oq_count) + (OQ_AW+2)'(r_a_valid) + (OQ_AW+2)'(r_c_valid);
    assign o_q_pop  = !i_q_empty && (inflight < (OQ_AW+2)'(OQ_DEPTH));

    prew_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_rec.col),
        .i_wr_data (wr_data),
        .i_rd_en   (o_q_pop),
        .i_rd_addr (i_q_data.col),
        .o_rd_data (rd_data)
    );

    always_comb begin
        lines   = r_a_fwd ? r_a_fwd_data : rd_data;
        above2  = lines[LINE_W-1:PIX_W];
        above1  = lines[PIX_W-1:0];
        wr_data = {above1, r_a_rec.pix};

        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = above2;
        n_win[5] = above1;
        n_win[8] = r_a_rec.pix;

        // zero padding outside the frame
        row_ok = {r_a_rec.bot_ok, 1'b1, r_a_rec.top_ok};
        col_ok = {r_a_rec.right_ok, 1'b1, r_a_rec.left_ok};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                tap[i][j] = (row_ok[i] && col_ok[j]) ? n_win[i*3+j] : '0;
            end
        end

        if (i_dir == DIR_HORIZONTAL) begin
            pos_sum = SUM_W'(tap[2][0]) + SUM_W'(tap[2][1]) + SUM_W'(tap[2][2]);
            neg_sum = SUM_W'(tap[0][0]) + SUM_W'(tap[0][1]) + SUM_W'(tap[0][2]);
        end else begin
            pos_sum = SUM_W'(tap[0][2]) + SUM_W'(tap[1][2]) + SUM_W'(tap[2][2]);
            neg_sum = SUM_W'(tap[0][0]) + SUM_W'(tap[1][0]) + SUM_W'(tap[2][0]);
        end
        val = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});

        n_max = (r_c_val > r_max) ? r_c_val : r_max;
        n_min = (r_c_val < r_min) ? r_c_val : r_min;

        res.val     = r_c_val;
        res.col     = r_c_col;
        res.row     = r_c_row;
        res.max_val = n_max;
        res.min_val = n_min;
        res.last    = r_c_last;
    end

    // stage A payload; same-address write in the pop cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_rec      <= i_q_data;
            r_a_fwd_data <= wr_data;
        end
        if (r_a_valid) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
        r_c_val  <= val;
        r_c_col  <= r_a_rec.ec;
        r_c_row  <= r_a_rec.er;
        r_c_last <= r_a_rec.last;
        if (r_c_valid) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    assign o_empty = r_oq_count == '0;
    assign oq_pop  = i_pop && !o_empty;
    assign o_res   = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_a_fwd    <= 1'b0;
            r_c_valid  <= 1'b0;
            r_max      <= VAL_MOST_NEG;
            r_min      <= VAL_MOST_POS;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            r_a_valid <= o_q_pop;
            r_a_fwd   <= o_q_pop && r_a_valid && (r_a_rec.col == i_q_data.col);
            r_c_valid <= r_a_valid && r_a_rec.have;

            if (i_restart || (r_c_valid && r_c_last)) begin
                r_max <= VAL_MOST_NEG;
                r_min <= VAL_MOST_POS;
            end else if (r_c_valid) begin
                r_max <= n_max;
                r_min <= n_min;
            end

            if (r_c_valid) begin
                r_oq_wr <= r_oq_wr + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OQ_AW'(1);
            end
            if (r_c_valid && !oq_pop) begin
                r_oq_count <= r_oq_count + (OQ_AW+1)'(1);
            end else if (oq_pop && !r_c_valid) begin
                r_oq_count <= r_oq_count - (OQ_AW+1)'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inflight <= (OQ_AW+2)'(OQ_DEPTH))
        else $error("more items in flight than result queue entries");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_fwd |-> ($past(r_a_valid) && ($past(r_a_rec.col) == r_a_rec.col)))
        else $error("line-store forward without a colliding write");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_last) |=> (r_max == VAL_MOST_NEG && r_min == VAL_MOST_POS))
        else $error("running max/min not cleared after frame end");

endmodule

`default_nettype wire

// File: rtl/edge_filter_3x3_prewitt_top.sv
// Top level of the 3x3 Prewitt edge filter: configuration registers and the
// wiring of front end, item queue and back end. Depends on prew_pkg and all rtl modules.
//
// RGB pixels enter in raster order through a queue-style port (push/full) and
// each is summed to a 10-bit intensity; results leave through a second queue port
// (empty/pop) carrying the signed Prewitt response, its position, the running
// max/min of the frame and a frame-last flag. The result for a position appears
// W+1 items after the pixel that opens it; after the last pixel of a frame, W+1
// flush items (kind 1) drain the final positions, and a flush sent while the frame
// is still taking pixels is swallowed without a result. The block takes one item
// per clock unless the queues fill, set by the single line-store RAM (one read and
// one write per item); a result passes the item queue, the line-store read, the
// kernel and the result queue on its way to the result ports. The line stores
// need no clearing after reset: every line entry that reaches the kernel was
// written earlier in the same frame. A configuration write restarts the frame and
// must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module edge_filter_3x3_prewitt_top import prew_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   i_kind,
    input  wire logic [CH_W-1:0]        i_red,
    input  wire logic [CH_W-1:0]        i_green,
    input  wire logic [CH_W-1:0]        i_blue,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [VAL_W-1:0]     o_edge_value,
    output logic [COL_W-1:0]            o_out_column,
    output logic [ROW_W-1:0]            o_out_row,
    output logic signed [VAL_W-1:0]     o_running_max,
    output logic signed [VAL_W-1:0]     o_running_min,
    output logic                        o_frame_last,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [WCFG_W-1:0] r_img_width;
    logic [ROW_W-1:0]  r_img_height;
    logic              r_edge_dir;

    logic  restart;
    t_geom geom;
    logic  fe_wr_en;
    t_rec  fe_rec;
    logic  q_pop;
    logic  q_empty;
    t_rec  q_data;
    t_res  res;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (i_cfg_index)
            CFG_IMAGE_WIDTH:    restart = i_cfg_valid;
            CFG_IMAGE_HEIGHT:   restart = i_cfg_valid;
            CFG_EDGE_DIRECTION: restart = i_cfg_valid;
            default:            restart = 1'b0;
        endcase

        if (r_img_width == '0) begin
            geom.width = EW_W'(1);
        end else if (int'(r_img_width) > MAX_WIDTH) begin
            geom.width = EW_W'(MAX_WIDTH);
        end else begin
            geom.width = EW_W'(r_img_width);
        end
        geom.height = (r_img_height == '0) ? ROW_W'(1) : r_img_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RST_IMAGE_WIDTH;
            r_img_height <= RST_IMAGE_HEIGHT;
            r_edge_dir   <= DIR_VERTICAL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_img_width  <= i_cfg_data[WCFG_W-1:0];
                CFG_IMAGE_HEIGHT:   r_img_height <= i_cfg_data[ROW_W-1:0];
                CFG_EDGE_DIRECTION: r_edge_dir   <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    prew_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_push    (push),
        .i_full    (full),
        .i_kind    (i_kind),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_wr_en   (fe_wr_en),
        .o_rec     (fe_rec)
    );

    prew_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_wr_en),
        .i_data  (fe_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    prew_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dir     (r_edge_dir),
        .i_restart (restart),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_edge_value  = res.val;
    assign o_out_column  = res.col;
    assign o_out_row     = res.row;
    assign o_running_max = res.max_val;
    assign o_running_min = res.min_val;
    assign o_frame_last  = res.last;

endmodule

`default_nettype wire
